// File: rtl/mrac_pkg.sv
// Shared types and constants for the memory region access checker.
package mrac_pkg;

  localparam int unsigned OwnW = 4;
  localparam logic [OwnW-1:0] NoOwner = 4'd8;

  typedef enum logic [1:0] {
    OP_CHECK       = 2'd0,
    OP_LOAD_REGION = 2'd1,
    OP_LOAD_OWNER  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_TASK_COUNT   = 2'd0,
    CFG_APP_COUNT    = 2'd1,
    CFG_REGION_COUNT = 2'd2,
    CFG_TRUSTED_MASK = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEARCH
  } state_e;

  // Control part of a check as it walks down the region cells.
  typedef struct packed {
    logic            active;
    logic            hit;
    logic [OwnW-1:0] own;
  } probe_t;

endpackage

// File: rtl/mrac_cell.sv
// One region cell: holds a region entry and tests a passing probe against it.
module mrac_cell import mrac_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  load_i,
  input  logic [ADDR_WIDTH-1:0] ld_start_i,
  input  logic [ADDR_WIDTH-1:0] ld_last_i,
  input  logic                  ld_ok_i,
  input  logic [OwnW-1:0]       ld_app_i,
  input  probe_t                probe_i,
  input  logic [ADDR_WIDTH-1:0] addr_i,
  input  logic [ADDR_WIDTH-1:0] last_i,
  output probe_t                probe_o,
  output logic [ADDR_WIDTH-1:0] addr_o,
  output logic [ADDR_WIDTH-1:0] last_o
);

  logic [ADDR_WIDTH-1:0] start_q, rlast_q;
  logic [OwnW-1:0]       app_q;
  logic                  ok_q;

  probe_t                probe_q;
  logic [ADDR_WIDTH-1:0] addr_q, last_q;
  logic                  fits;

  // ok_q is clear for a zero-size or wrapping region, so it never matches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (load_i) begin
      ok_q <= ld_ok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      start_q <= ld_start_i;
      rlast_q <= ld_last_i;
      app_q   <= ld_app_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
    last_q <= last_i;
  end

  assign fits = en_i && ok_q && (app_q == probe_q.own) &&
                (addr_q >= start_q) && (last_q <= rlast_q);

  always_comb begin
    probe_o     = probe_q;
    probe_o.hit = probe_q.hit | (probe_q.active & fits);
  end

  assign addr_o = addr_q;
  assign last_o = last_q;

endmodule

// File: rtl/memory_region_access_checker_unit.sv
// Memory region access checker: a check that is not decided early runs once down a row of region cells.
//
// Loads (opcode 1 region entry, opcode 2 task owner) are written when taken and busy
// stays low. A check raises busy through its pre-check state and, if it must walk
// the region cells, through the search; a check that task, arguments, app count, owner
// or trust already decide skips the walk. result_valid_o pulses for one cycle with
// access_granted_o in the first cycle in which busy is low again, and a new transaction
// can start in that same cycle. The walk time is set by the row of NUM_REGIONS cells,
// one cell per cycle, after a registered read of the task owner table and the pre-checks.
// The result strobe cannot be held off by the receiver.
module memory_region_access_checker_unit import mrac_pkg::*; #(
  parameter int unsigned NUM_REGIONS = 16,
  parameter int unsigned NUM_TASKS   = 32,
  parameter int unsigned NUM_APPS    = 8,
  parameter int unsigned ADDR_WIDTH  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            opcode_i,
  input  logic [7:0]            task_id_i,
  input  logic [ADDR_WIDTH-1:0] address_i,
  input  logic [ADDR_WIDTH-1:0] size_i,
  input  logic [4:0]            entry_index_i,
  input  logic [3:0]            owner_app_i,
  output logic                  result_valid_o,
  output logic                  access_granted_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  localparam int unsigned TaskIdxW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // configuration registers
  logic [5:0] task_count_q;
  logic [3:0] app_count_q;
  logic [4:0] region_count_q;
  logic [7:0] trusted_mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q   <= '0;
      app_count_q    <= '0;
      region_count_q <= '0;
      trusted_mask_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TASK_COUNT:   task_count_q   <= cfg_data_i[5:0];
        CFG_APP_COUNT:    app_count_q    <= cfg_data_i[3:0];
        CFG_REGION_COUNT: region_count_q <= cfg_data_i[4:0];
        CFG_TRUSTED_MASK: trusted_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // transaction decode
  logic accept, chk_acc, rgn_acc, own_acc;

  assign accept  = start && !busy;
  assign chk_acc = accept && (op_e'(opcode_i) == OP_CHECK);
  assign rgn_acc = accept && (op_e'(opcode_i) == OP_LOAD_REGION);
  assign own_acc = accept && (op_e'(opcode_i) == OP_LOAD_OWNER);

  // task owner table, entries read as no owner until written
  logic [OwnW-1:0]     owner_mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] owner_vld_q;
  logic [8:0]          widx9;
  logic [TaskIdxW-1:0] widx, ridx;
  logic                widx_ok;
  logic [OwnW-1:0]     mem_rd_q;
  logic                vld_rd_q;

  assign widx9   = 9'(entry_index_i);
  assign widx_ok = widx9 < 9'(NUM_TASKS);
  assign widx    = widx9[TaskIdxW-1:0];
  assign ridx    = task_id_i[TaskIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (own_acc && widx_ok) begin
      owner_mem[widx] <= owner_app_i;
    end
    if (chk_acc) begin
      mem_rd_q <= owner_mem[ridx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_vld_q <= '0;
      vld_rd_q    <= 1'b0;
    end else begin
      if (own_acc && widx_ok) begin
        owner_vld_q[widx] <= 1'b1;
      end
      if (chk_acc) begin
        vld_rd_q <= owner_vld_q[ridx];
      end
    end
  end

  // check operands
  logic [ADDR_WIDTH-1:0] addr_q, size_q;
  logic                  task_ok_q;

  always_ff @(posedge clk_i) begin
    if (chk_acc) begin
      addr_q    <= address_i;
      size_q    <= size_i;
      task_ok_q <= (9'(task_id_i) < 9'(NUM_TASKS)) && (task_id_i < 8'(task_count_q));
    end
  end

  // pre-checks
  logic [OwnW-1:0]       own;
  logic                  own_ok, trusted, zero_arg;
  logic [ADDR_WIDTH:0]   chk_sum;
  logic [ADDR_WIDTH-1:0] chk_last;
  logic                  chk_wrap;
  logic                  need_search, early_grant;

  assign own      = vld_rd_q ? mem_rd_q : NoOwner;
  assign own_ok   = (own < app_count_q) && (6'(own) < 6'(NUM_APPS));
  assign trusted  = !own[3] && trusted_mask_q[own[2:0]];
  assign zero_arg = (addr_q == '0) || (size_q == '0);
  assign chk_sum  = (ADDR_WIDTH+1)'(addr_q) + (ADDR_WIDTH+1)'(size_q - ADDR_WIDTH'(1));
  assign chk_last = chk_sum[ADDR_WIDTH-1:0];
  assign chk_wrap = chk_sum[ADDR_WIDTH];

  always_comb begin
    need_search = 1'b0;
    early_grant = 1'b0;
    if (!task_ok_q || zero_arg) begin
      early_grant = 1'b0;
    end else if (app_count_q == '0) begin
      early_grant = 1'b1;
    end else if (!own_ok) begin
      early_grant = 1'b0;
    end else if (trusted) begin
      early_grant = 1'b1;
    end else if (!chk_wrap) begin
      need_search = 1'b1;
    end
  end

  // region load data: precompute last byte and fit flag once
  logic [ADDR_WIDTH:0]   rgn_sum;
  logic                  rgn_ok;

  assign rgn_sum = (ADDR_WIDTH+1)'(address_i) + (ADDR_WIDTH+1)'(size_i - ADDR_WIDTH'(1));
  assign rgn_ok  = (size_i != '0) && !rgn_sum[ADDR_WIDTH];

  // region cell row
  probe_t                chain_p [NUM_REGIONS+1];
  logic [ADDR_WIDTH-1:0] chain_a [NUM_REGIONS+1];
  logic [ADDR_WIDTH-1:0] chain_l [NUM_REGIONS+1];
  logic                  inject;
  logic [6:0]            rcount;

  assign rcount = 7'(region_count_q);

  always_comb begin
    chain_p[0]        = '0;
    chain_p[0].active = inject;
    chain_p[0].own    = own;
  end
  assign chain_a[0] = addr_q;
  assign chain_l[0] = chk_last;

  for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_cell
    mrac_cell #(
      .ADDR_WIDTH(ADDR_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (7'(g) < rcount),
      .load_i    (rgn_acc && (7'(entry_index_i) == 7'(g))),
      .ld_start_i(address_i),
      .ld_last_i (rgn_sum[ADDR_WIDTH-1:0]),
      .ld_ok_i   (rgn_ok),
      .ld_app_i  (owner_app_i),
      .probe_i   (chain_p[g]),
      .addr_i    (chain_a[g]),
      .last_i    (chain_l[g]),
      .probe_o   (chain_p[g+1]),
      .addr_o    (chain_a[g+1]),
      .last_o    (chain_l[g+1])
    );
  end

  probe_t exit_p;
  assign exit_p = chain_p[NUM_REGIONS];

  // sequencer
  state_e state_q, state_d;
  logic   res_set, res_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (chk_acc) state_d = ST_PREP;
      ST_PREP:   state_d = need_search ? ST_SEARCH : ST_IDLE;
      ST_SEARCH: if (exit_p.active) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state_q != ST_IDLE);
    inject  = 1'b0;
    res_set = 1'b0;
    res_val = 1'b0;
    case (state_q)
      ST_PREP: begin
        inject  = need_search;
        res_set = !need_search;
        res_val = early_grant;
      end
      ST_SEARCH: begin
        res_set = exit_p.active;
        res_val = exit_p.hit;
      end
      default: ;
    endcase
  end

  logic result_valid_q, access_granted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= res_set;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_set) begin
      access_granted_q <= res_val;
    end
  end

  assign result_valid_o   = result_valid_q;
  assign access_granted_o = access_granted_q;

  // assertions
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> (state_q == ST_IDLE))
    else $error("result strobe while a check is still running");

  a_check_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_acc |=> (state_q == ST_PREP))
    else $error("accepted check did not enter pre-check");

  a_exit_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_p.active |-> (state_q == ST_SEARCH))
    else $error("probe left the region cells outside a search");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !chk_acc) |=> !result_valid_q)
    else $error("load transaction produced a result");

endmodule
